@@ src/wtv_pkg.sv @@
package wtv_pkg;

	localparam int OP_W       = 2;
	localparam int VEL_W      = 7;
	localparam int PHASE_W    = 32;
	localparam int SAMPLE_W   = 16;
	localparam int TABLE_AW   = 10;
	localparam int TABLE_DEPTH = 1 << TABLE_AW;
	localparam int TIME_W     = 16;
	localparam int LEVEL_W    = 32;
	localparam int COUNT_W    = 18;
	localparam int BLEND_W    = TIME_W + VEL_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MIX_SHIFT  = 15;

	localparam int PHASE_SHIFT_DFLT = 22;

	localparam logic [VEL_W-1:0]   VEL_MAX       = 7'h7f;
	localparam logic [COUNT_W-1:0] SUSTAIN_TICKS = 18'd100;

	localparam logic [OP_W-1:0] OP_NOTE_ON = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ATK_SOFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATK_HARD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RLS_SOFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RLS_HARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN  = 3'd5;

	localparam logic [1:0] STG_ATTACK  = 2'd0;
	localparam logic [1:0] STG_DECAY   = 2'd1;
	localparam logic [1:0] STG_SUSTAIN = 2'd2;
	localparam logic [1:0] STG_RELEASE = 2'd3;

	typedef enum logic [2:0] {
		ENV_NONE,
		ENV_STEP,
		ENV_DECAY,
		ENV_SUSTAIN,
		ENV_RELEASE,
		ENV_RECHECK,
		ENV_END
	} env_op_t;

	typedef enum logic [2:0] {
		BLEND_NONE,
		BLEND_ATK_LO,
		BLEND_ATK_HI,
		BLEND_RLS_LO,
		BLEND_RLS_HI
	} blend_op_t;

	typedef enum logic [1:0] {
		DIV_ATTACK,
		DIV_DECAY,
		DIV_RELEASE
	} div_sel_t;

	typedef struct packed {
		logic      capture;
		blend_op_t blend;
		logic      note_init;
		logic      set_release;
		logic      table_write;
		logic      phase_adv;
		logic      sample_read;
		env_op_t   env_op;
		logic      div_start;
		div_sel_t  div_sel;
		logic      mul;
		logic      out_load;
		logic      out_pass;
	} dp_cmd_t;

	typedef struct packed {
		logic       active;
		logic       release_flag;
		logic       count_zero;
		logic [1:0] stage;
		logic       div_done;
	} dp_status_t;

endpackage

@@ src/wtv_in_if.sv @@
interface wtv_in_if import wtv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            operation;
	logic [VEL_W-1:0]           velocity;
	logic [PHASE_W-1:0]         phase_rate;
	logic signed [SAMPLE_W-1:0] mix_in;
	logic [TABLE_AW-1:0]        table_index;
	logic signed [SAMPLE_W-1:0] table_value;

	modport source (
		output valid, operation, velocity, phase_rate, mix_in, table_index, table_value,
		input  ready
	);
	modport sink (
		input  valid, operation, velocity, phase_rate, mix_in, table_index, table_value,
		output ready
	);
endinterface

@@ src/wtv_out_if.sv @@
interface wtv_out_if import wtv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mix_out;
	logic                       voice_active;

	modport source (output valid, mix_out, voice_active, input ready);
	modport sink (input valid, mix_out, voice_active, output ready);
endinterface

@@ src/wtv_cfg_if.sv @@
interface wtv_cfg_if import wtv_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/wtv_ram.sv @@
module wtv_ram import wtv_pkg::*; #(
	parameter int WIDTH = SAMPLE_W,
	parameter int DEPTH = TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/wtv_div.sv @@
module wtv_div import wtv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [LEVEL_W-1:0] num,
	input  logic [COUNT_W-1:0] den,
	output logic               done,
	output logic [LEVEL_W-1:0] quo
);

	localparam int ITER_W = $clog2(LEVEL_W);

	logic               busy_q;
	logic               done_q;
	logic [ITER_W-1:0]  cnt_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] den_q;
	logic               neg_q;
	logic               zero_q;
	logic [COUNT_W:0]   trial;

	// One quotient bit per cycle on the magnitude; the sign is applied at the end.
	assign trial = {rem_q, quo_q[LEVEL_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= num[LEVEL_W-1] ? (LEVEL_W'(0) - num) : num;
			rem_q  <= '0;
			den_q  <= den;
			neg_q  <= num[LEVEL_W-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (!trial[COUNT_W]) begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[COUNT_W-2:0], quo_q[LEVEL_W-1]};
				quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 : (neg_q ? (LEVEL_W'(0) - quo_q) : quo_q);

endmodule

@@ src/wtv_dp.sv @@
module wtv_dp import wtv_pkg::*; #(
	parameter int PHASE_SHIFT = PHASE_SHIFT_DFLT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic [VEL_W-1:0]           velocity,
	input  logic [PHASE_W-1:0]         phase_rate,
	input  logic signed [SAMPLE_W-1:0] mix_in,
	input  logic [TABLE_AW-1:0]        table_index,
	input  logic signed [SAMPLE_W-1:0] table_value,
	output logic signed [SAMPLE_W-1:0] mix_out,
	output logic                       voice_active
);

	logic [TIME_W-1:0]   atk_soft_q, atk_hard_q, rls_soft_q, rls_hard_q;
	logic [VEL_W-1:0]    volume_q, sustain_q;

	logic [VEL_W-1:0]    vel_q;
	logic [PHASE_W-1:0]  rate_q;
	logic [SAMPLE_W-1:0] mix_q;
	logic [TABLE_AW-1:0] tidx_q;
	logic [SAMPLE_W-1:0] tval_q;

	logic [BLEND_W-1:0]  blend_acc_q;
	logic [TIME_W-1:0]   atk_q;
	logic [TIME_W-1:0]   release_len_q;

	logic [PHASE_W-1:0]  phase_q, inc_q;
	logic [1:0]          stage_q;
	logic                rel_q, active_q;
	logic [COUNT_W-1:0]  count_q, decay_len_q;
	logic [LEVEL_W-1:0]  step_q, level_q, sust_q;

	logic signed [2*SAMPLE_W-1:0] prod_s1;
	logic [SAMPLE_W-1:0]          mix_out_q;
	logic                         active_out_q;

	logic [TIME_W-1:0]     mul_a;
	logic [VEL_W-1:0]      mul_b;
	logic [BLEND_W-1:0]    blend_prod, blend_sum;
	logic [2*VEL_W-1:0]    sust_prod;
	logic [LEVEL_W-1:0]    peak;
	logic [PHASE_W-1:0]    phase_shifted;
	logic [SAMPLE_W-1:0]   sample;
	logic [LEVEL_W-1:0]    div_num;
	logic [COUNT_W-1:0]    div_den;
	logic                  div_done;
	logic [LEVEL_W-1:0]    div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atk_soft_q <= '0;
			atk_hard_q <= '0;
			rls_soft_q <= '0;
			rls_hard_q <= '0;
			volume_q   <= '0;
			sustain_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATK_SOFT: atk_soft_q <= cfg_data;
				REG_ATK_HARD: atk_hard_q <= cfg_data;
				REG_RLS_SOFT: rls_soft_q <= cfg_data;
				REG_RLS_HARD: rls_hard_q <= cfg_data;
				REG_VOLUME:   volume_q   <= cfg_data[VEL_W-1:0];
				REG_SUSTAIN:  sustain_q  <= cfg_data[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vel_q  <= velocity;
			rate_q <= phase_rate;
			mix_q  <= mix_in;
			tidx_q <= table_index;
			tval_q <= table_value;
		end
	end

	// Velocity blend: (soft * (127 - vel) + hard * vel) >> 7, from two products.
	always_comb begin
		unique case (cmd.blend)
			BLEND_ATK_LO: begin
				mul_a = atk_soft_q;
				mul_b = VEL_MAX - vel_q;
			end
			BLEND_ATK_HI: begin
				mul_a = atk_hard_q;
				mul_b = vel_q;
			end
			BLEND_RLS_LO: begin
				mul_a = rls_soft_q;
				mul_b = VEL_MAX - vel_q;
			end
			BLEND_RLS_HI: begin
				mul_a = rls_hard_q;
				mul_b = vel_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign blend_prod = BLEND_W'(mul_a) * BLEND_W'(mul_b);
	assign blend_sum  = blend_acc_q + blend_prod;
	assign sust_prod  = volume_q * sustain_q;
	assign peak       = {2'b00, volume_q, 23'd0};

	always_ff @(posedge clk) begin
		unique case (cmd.blend)
			BLEND_ATK_LO, BLEND_RLS_LO: blend_acc_q <= blend_prod;
			BLEND_ATK_HI: atk_q <= blend_sum[BLEND_W-1 -: TIME_W];
			default: ;
		endcase
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_ATTACK: begin
				div_num = peak;
				div_den = {2'b00, atk_q};
			end
			DIV_DECAY: begin
				div_num = sust_q - level_q;
				div_den = decay_len_q;
			end
			DIV_RELEASE: begin
				div_num = LEVEL_W'(0) - level_q;
				div_den = {2'b00, release_len_q};
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	wtv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			inc_q         <= '0;
			stage_q       <= STG_ATTACK;
			rel_q         <= 1'b0;
			active_q      <= 1'b0;
			count_q       <= '0;
			step_q        <= '0;
			level_q       <= '0;
			decay_len_q   <= '0;
			sust_q        <= '0;
			release_len_q <= '0;
		end else begin
			if (cmd.blend == BLEND_RLS_HI) begin
				release_len_q <= blend_sum[BLEND_W-1 -: TIME_W];
			end
			if (cmd.note_init) begin
				phase_q     <= '0;
				inc_q       <= rate_q;
				stage_q     <= STG_ATTACK;
				level_q     <= '0;
				rel_q       <= 1'b0;
				active_q    <= 1'b1;
				count_q     <= {2'b00, atk_q};
				decay_len_q <= {1'b0, atk_q, 1'b0};
				sust_q      <= {2'b00, sust_prod, 16'd0};
			end
			if (cmd.set_release) begin
				rel_q <= 1'b1;
			end
			if (cmd.phase_adv) begin
				phase_q <= phase_q + inc_q;
			end
			unique case (cmd.env_op)
				ENV_STEP: begin
					count_q <= count_q - 1'b1;
					level_q <= level_q + step_q;
				end
				ENV_DECAY: begin
					stage_q <= STG_DECAY;
					count_q <= decay_len_q;
				end
				ENV_SUSTAIN: begin
					stage_q <= STG_SUSTAIN;
					count_q <= SUSTAIN_TICKS;
					step_q  <= '0;
				end
				ENV_RELEASE: begin
					stage_q <= STG_RELEASE;
					count_q <= {2'b00, release_len_q};
				end
				ENV_RECHECK: count_q <= SUSTAIN_TICKS;
				ENV_END:     active_q <= 1'b0;
				default: ;
			endcase
			if (div_done) begin
				step_q <= div_quo;
			end
		end
	end

	assign phase_shifted = phase_q >> PHASE_SHIFT;

	wtv_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.table_write),
		.waddr (tidx_q),
		.wdata (tval_q),
		.re    (cmd.sample_read),
		.raddr (phase_shifted[TABLE_AW-1:0]),
		.rdata (sample)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= $signed(sample) * $signed(level_q[LEVEL_W-1 -: SAMPLE_W]);
		end
		if (cmd.out_load) begin
			mix_out_q    <= cmd.out_pass ? mix_q : (mix_q + prod_s1[MIX_SHIFT +: SAMPLE_W]);
			active_out_q <= !cmd.out_pass;
		end
	end

	assign mix_out      = mix_out_q;
	assign voice_active = active_out_q;

	assign status.active       = active_q;
	assign status.release_flag = rel_q;
	assign status.count_zero   = (count_q == '0);
	assign status.stage        = stage_q;
	assign status.div_done     = div_done;

endmodule

@@ src/wtv_ctrl.sv @@
module wtv_ctrl import wtv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dp_cmd_t         cmd,
	input  dp_status_t      status
);

	localparam logic [3:0] S_IDLE        = 4'd0;
	localparam logic [3:0] S_NOTE_ATK_LO = 4'd1;
	localparam logic [3:0] S_NOTE_ATK_HI = 4'd2;
	localparam logic [3:0] S_NOTE_RLS_LO = 4'd3;
	localparam logic [3:0] S_NOTE_RLS_HI = 4'd4;
	localparam logic [3:0] S_NOTE_INIT   = 4'd5;
	localparam logic [3:0] S_NOTE_DIV    = 4'd6;
	localparam logic [3:0] S_RELEASE     = 4'd7;
	localparam logic [3:0] S_WRITE       = 4'd8;
	localparam logic [3:0] S_PHASE       = 4'd9;
	localparam logic [3:0] S_READ        = 4'd10;
	localparam logic [3:0] S_ENV         = 4'd11;
	localparam logic [3:0] S_TICK_DIV    = 4'd12;
	localparam logic [3:0] S_MUL         = 4'd13;
	localparam logic [3:0] S_RESULT      = 4'd14;

	logic [3:0] state_q, state_d;
	logic       pass_q, pass_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		pass_d   = pass_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (in_op)
						OP_NOTE_ON: state_d = S_NOTE_ATK_LO;
						OP_RELEASE: state_d = S_RELEASE;
						OP_WRITE:   state_d = S_WRITE;
						OP_TICK: begin
							pass_d  = !status.active;
							state_d = status.active ? S_PHASE : S_RESULT;
						end
					endcase
				end
			end
			S_NOTE_ATK_LO: begin
				cmd.blend = BLEND_ATK_LO;
				state_d   = S_NOTE_ATK_HI;
			end
			S_NOTE_ATK_HI: begin
				cmd.blend = BLEND_ATK_HI;
				state_d   = S_NOTE_RLS_LO;
			end
			S_NOTE_RLS_LO: begin
				cmd.blend = BLEND_RLS_LO;
				state_d   = S_NOTE_RLS_HI;
			end
			S_NOTE_RLS_HI: begin
				cmd.blend = BLEND_RLS_HI;
				state_d   = S_NOTE_INIT;
			end
			S_NOTE_INIT: begin
				cmd.note_init = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_ATTACK;
				state_d       = S_NOTE_DIV;
			end
			S_NOTE_DIV: begin
				if (status.div_done) begin
					state_d = S_IDLE;
				end
			end
			S_RELEASE: begin
				cmd.set_release = 1'b1;
				state_d         = S_IDLE;
			end
			S_WRITE: begin
				cmd.table_write = 1'b1;
				state_d         = S_IDLE;
			end
			S_PHASE: begin
				cmd.phase_adv = 1'b1;
				state_d       = S_READ;
			end
			S_READ: begin
				cmd.sample_read = 1'b1;
				state_d         = S_ENV;
			end
			S_ENV: begin
				if (!status.count_zero) begin
					cmd.env_op = ENV_STEP;
					state_d    = S_MUL;
				end else begin
					unique case (status.stage)
						STG_ATTACK: begin
							cmd.env_op    = ENV_DECAY;
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_DECAY;
							state_d       = S_TICK_DIV;
						end
						STG_DECAY: begin
							cmd.env_op = ENV_SUSTAIN;
							state_d    = S_MUL;
						end
						STG_SUSTAIN: begin
							if (status.release_flag) begin
								cmd.env_op    = ENV_RELEASE;
								cmd.div_start = 1'b1;
								cmd.div_sel   = DIV_RELEASE;
								state_d       = S_TICK_DIV;
							end else begin
								cmd.env_op = ENV_RECHECK;
								state_d    = S_MUL;
							end
						end
						STG_RELEASE: begin
							cmd.env_op = ENV_END;
							pass_d     = 1'b1;
							state_d    = S_RESULT;
						end
					endcase
				end
			end
			S_TICK_DIV: begin
				if (status.div_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_pass = pass_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/wavetable_voice_with_envelope.sv @@
// An active sample tick goes through the phase, read, envelope, multiply and result states;
// one entering decay or release also waits in tick-divide for the step divider, one ending
// release skips multiply, and a tick on an idle voice goes straight to result. A note-on runs
// the velocity blend and waits for the same divider; release and table writes go back to idle after their
// own state. One word is in work at a time; the next is taken in idle, for a tick the cycle after its
// result is loaded. Reset clears the voice, the envelope and all settings to zero, but not the wavetable.
module wavetable_voice_with_envelope import wtv_pkg::*; #(
	parameter int PHASE_SHIFT = PHASE_SHIFT_DFLT
) (
	input  logic       clk,
	input  logic       arst_n,
	wtv_in_if.sink     items,
	wtv_out_if.source  results,
	wtv_cfg_if.sink    cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	wtv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_op     (items.operation),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	wtv_dp #(
		.PHASE_SHIFT (PHASE_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.velocity     (items.velocity),
		.phase_rate   (items.phase_rate),
		.mix_in       (items.mix_in),
		.table_index  (items.table_index),
		.table_value  (items.table_value),
		.mix_out      (results.mix_out),
		.voice_active (results.voice_active)
	);

endmodule

@@ src/wtv_chk.sv @@
module wtv_chk import wtv_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] mix_out,
	input logic                voice_active
);

	// No result word may be offered while the block is held in reset.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mix_out) && $stable(voice_active))
		else $error("stalled result changed");

	// Every accepted word moves the controller out of idle, so the input closes right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accept");

	// A new result only follows a cycle in which the block was busy with a tick.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work");

endmodule

bind wavetable_voice_with_envelope wtv_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.mix_out      (results.mix_out),
	.voice_active (results.voice_active)
);

@@ verif/tb.sv @@
module tb;
	import wtv_pkg::*;

	localparam int PSH          = PHASE_SHIFT_DFLT;
	localparam int SETTLE_CYC   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int TBL_STEP_W   = 4;
	localparam int TBL_STRIDE   = 1 << TBL_STEP_W;
	localparam int TBL_FILLED   = TABLE_DEPTH / TBL_STRIDE;
	localparam logic [PHASE_W-1:0] RATE_MASK =
		~((PHASE_W'(1) << (PSH + TBL_STEP_W)) - PHASE_W'(1));

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [VEL_W-1:0]           vel;
		logic [PHASE_W-1:0]         rate;
		logic signed [SAMPLE_W-1:0] mix;
		logic [TABLE_AW-1:0]        idx;
		logic signed [SAMPLE_W-1:0] val;
	} voice_cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix;
		logic                       active;
	} voice_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	voice_cmd_t in_cmd = '0;
	logic       out_ready = 1'b0;
	logic       cfg_valid = 1'b0;
	reg_write_t cfg_word = '0;

	wtv_in_if  items_if();
	wtv_out_if results_if();
	wtv_cfg_if cfg_if();

	assign items_if.valid       = in_valid;
	assign items_if.operation   = in_cmd.op;
	assign items_if.velocity    = in_cmd.vel;
	assign items_if.phase_rate  = in_cmd.rate;
	assign items_if.mix_in      = in_cmd.mix;
	assign items_if.table_index = in_cmd.idx;
	assign items_if.table_value = in_cmd.val;
	assign results_if.ready     = out_ready;
	assign cfg_if.valid         = cfg_valid;
	assign cfg_if.index         = cfg_word.idx;
	assign cfg_if.data          = cfg_word.data;

	wavetable_voice_with_envelope #(.PHASE_SHIFT(PSH)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	voice_cmd_t  voice_cmds[$];
	voice_word_t mix_expected[$];
	reg_write_t  reg_writes[$];

	int in_pushed = 0;
	int in_taken = 0;
	int cfg_pushed = 0;
	int cfg_taken = 0;
	int errors = 0;
	int cycles = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	bit long_hold = 1'b0;
	int hold_count = 0;
	voice_word_t got_word;

	logic [TIME_W-1:0]          atk_soft = '0, atk_hard = '0, rls_soft = '0, rls_hard = '0;
	logic [VEL_W-1:0]           volume = '0, sustain = '0;
	logic [PHASE_W-1:0]         ph_acc = '0, ph_inc = '0;
	logic [1:0]                 stage = STG_ATTACK;
	bit                         rel_flag = 1'b0, act_flag = 1'b0;
	logic [COUNT_W-1:0]         count = '0, decay_len = '0;
	logic signed [LEVEL_W-1:0]  step = '0, level = '0, sus_level = '0;
	logic [TIME_W-1:0]          rls_len = '0;
	logic signed [SAMPLE_W-1:0] wave[TABLE_DEPTH];

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [LEVEL_W-1:0] level_div(input longint num, input longint den);
		longint q;
		if (den == 0)
			return '0;
		q = num / den;
		return q[LEVEL_W-1:0];
	endfunction

	task automatic advance_voice(input voice_cmd_t c);
		longint vel, atk, rls, scaled;
		logic signed [SAMPLE_W-1:0] smp;
		voice_word_t w;
		vel = c.vel;
		w.mix = c.mix;
		w.active = 1'b0;
		case (c.op)
			OP_NOTE_ON: begin
				atk = (longint'(atk_soft) * (longint'(VEL_MAX) - vel) + longint'(atk_hard) * vel) >>> 7;
				rls = (longint'(rls_soft) * (longint'(VEL_MAX) - vel) + longint'(rls_hard) * vel) >>> 7;
				ph_acc = '0;
				ph_inc = c.rate;
				stage = STG_ATTACK;
				level = '0;
				rel_flag = 1'b0;
				act_flag = 1'b1;
				count = COUNT_W'(atk);
				step = level_div(longint'(volume) << 23, atk);
				decay_len = COUNT_W'(atk * 2);
				sus_level = LEVEL_W'((longint'(volume) << 16) * longint'(sustain));
				rls_len = TIME_W'(rls);
			end
			OP_RELEASE: rel_flag = 1'b1;
			OP_WRITE: wave[c.idx] = c.val;
			OP_TICK: begin
				if (act_flag) begin
					ph_acc = ph_acc + ph_inc;
					smp = wave[TABLE_AW'(ph_acc >> PSH)];
					if (count != 0) begin
						count = count - 1'b1;
						level = level + step;
					end else begin
						case (stage)
							STG_ATTACK: begin
								stage = STG_DECAY;
								count = decay_len;
								step = level_div(longint'(sus_level) - longint'(level), longint'(decay_len));
							end
							STG_DECAY: begin
								stage = STG_SUSTAIN;
								count = SUSTAIN_TICKS;
								step = '0;
							end
							STG_SUSTAIN: begin
								if (rel_flag) begin
									stage = STG_RELEASE;
									count = COUNT_W'(rls_len);
									step = level_div(-longint'(level), longint'(rls_len));
								end else begin
									count = SUSTAIN_TICKS;
								end
							end
							STG_RELEASE: act_flag = 1'b0;
						endcase
					end
					if (act_flag) begin
						scaled = (longint'(smp) * (longint'(level) >>> 16)) >>> 15;
						w.mix = SAMPLE_W'(longint'(c.mix) + scaled);
						w.active = 1'b1;
					end
				end
				mix_expected.push_back(w);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && items_if.ready) begin
				advance_voice(in_cmd);
				in_taken++;
			end
			if (!in_valid || items_if.ready) begin
				if (voice_cmds.size() > 0 && $urandom_range(99, 0) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_cmd <= voice_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_if.ready) begin
				case (cfg_word.idx)
					REG_ATK_SOFT: atk_soft = cfg_word.data;
					REG_ATK_HARD: atk_hard = cfg_word.data;
					REG_RLS_SOFT: rls_soft = cfg_word.data;
					REG_RLS_HARD: rls_hard = cfg_word.data;
					REG_VOLUME:   volume = cfg_word.data[VEL_W-1:0];
					REG_SUSTAIN:  sustain = cfg_word.data[VEL_W-1:0];
					default: ;
				endcase
				cfg_taken++;
			end
			if (!cfg_valid || cfg_if.ready) begin
				if (reg_writes.size() > 0) begin
					cfg_valid <= 1'b1;
					cfg_word <= reg_writes.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (results_if.valid && out_ready) begin
				if (mix_expected.size() == 0) begin
					$error("unexpected word: mix_out %0d voice_active %0d",
						results_if.mix_out, results_if.voice_active);
					errors++;
				end else begin
					got_word = mix_expected.pop_front();
					if (results_if.mix_out !== got_word.mix) begin
						$error("mix_out expected %0d actual %0d", got_word.mix, results_if.mix_out);
						errors++;
					end
					if (results_if.voice_active !== got_word.active) begin
						$error("voice_active expected %0d actual %0d",
							got_word.active, results_if.voice_active);
						errors++;
					end
				end
			end
			if (long_hold && hold_count < HOLD_CYCLES) begin
				hold_count <= hold_count + 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= out_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(99, 0);
		if (r < 5)
			return -16'sd32768;
		if (r < 10)
			return 16'sd32767;
		if (r < 13)
			return '0;
		return SAMPLE_W'($urandom);
	endfunction

	function automatic logic [VEL_W-1:0] rand_vel();
		int r;
		r = $urandom_range(99, 0);
		if (r < 8)
			return '0;
		if (r < 16)
			return VEL_MAX;
		return VEL_W'($urandom);
	endfunction

	// Rates keep the phase on the filled table entries, every sixteenth one.
	function automatic logic [PHASE_W-1:0] rand_rate();
		int r;
		logic [PHASE_W-1:0] raw;
		r = $urandom_range(99, 0);
		if (r < 5)
			raw = '0;
		else if (r < 10)
			raw = '1;
		else if (r < 40)
			raw = PHASE_W'($urandom_range(32'h1000_0000, 0));
		else
			raw = $urandom;
		return raw & RATE_MASK;
	endfunction

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VEL_W-1:0] vel,
			input logic [PHASE_W-1:0] rate, input logic signed [SAMPLE_W-1:0] mix,
			input logic [TABLE_AW-1:0] idx, input logic signed [SAMPLE_W-1:0] val);
		voice_cmds.push_back('{op, vel, rate, mix, idx, val});
		in_pushed++;
	endtask

	task automatic send_random(input logic [OP_W-1:0] op);
		send_cmd(op, rand_vel(), rand_rate(), rand_sample(), TABLE_AW'($urandom), rand_sample());
	endtask

	task automatic wait_taken();
		while (in_taken != in_pushed)
			@(posedge clk);
	endtask

	task automatic drain_voice();
		while (in_taken != in_pushed || mix_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_settings(input logic [TIME_W-1:0] a_s, a_h, r_s, r_h,
			input logic [VEL_W-1:0] vol, sus);
		drain_voice();
		reg_writes.push_back('{REG_ATK_SOFT, a_s});
		reg_writes.push_back('{REG_ATK_HARD, a_h});
		reg_writes.push_back('{REG_RLS_SOFT, r_s});
		reg_writes.push_back('{REG_RLS_HARD, r_h});
		reg_writes.push_back('{REG_VOLUME, CFG_DATA_W'(vol)});
		reg_writes.push_back('{REG_SUSTAIN, CFG_DATA_W'(sus)});
		cfg_pushed += 6;
		while (cfg_taken != cfg_pushed)
			@(posedge clk);
	endtask

	task automatic play_notes(input int notes, input bit full);
		int amax, rmax, ticks, rel_at, cap, r;
		bit released;
		amax = (atk_soft > atk_hard) ? int'(atk_soft) : int'(atk_hard);
		rmax = (rls_soft > rls_hard) ? int'(rls_soft) : int'(rls_hard);
		for (int n = 0; n < notes; n++) begin
			send_random(OP_NOTE_ON);
			ticks = 0;
			released = 1'b0;
			rel_at = full ? $urandom_range(3 * amax + 110, 0) : $urandom_range(30, 0);
			cap = full ? 3 * amax + rmax + 400 : $urandom_range(40, 5);
			while (ticks < cap) begin
				repeat (8) begin
					r = $urandom_range(99, 0);
					if (r < 6) begin
						send_random(OP_WRITE);
					end else if (r < 9) begin
						send_random(OP_RELEASE);
					end else begin
						send_random(OP_TICK);
						ticks++;
						if (!released && ticks >= rel_at) begin
							send_random(OP_RELEASE);
							released = 1'b1;
						end
					end
				end
				wait_taken();
				if ($urandom_range(9, 0) == 0) begin
					while (mix_expected.size() != 0)
						@(posedge clk);
				end
				if (full && released && !act_flag)
					break;
			end
			if (full) begin
				repeat (3) send_random(OP_TICK);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < TBL_FILLED; i++) begin
			send_cmd(OP_WRITE, rand_vel(), $urandom, rand_sample(), TABLE_AW'(i * TBL_STRIDE),
				(i == 0) ? -16'sd32768 : (i == TBL_FILLED - 1) ? 16'sd32767 : rand_sample());
		end
		drain_voice();

		send_cmd(OP_TICK, '0, '0, -16'sd32768, '0, '0);
		send_cmd(OP_TICK, VEL_MAX, '1, 16'sd32767, '1, '1);
		send_cmd(OP_RELEASE, '0, '0, '0, '0, '0);
		send_cmd(OP_NOTE_ON, '0, '0, '0, '0, '0);
		send_cmd(OP_TICK, '0, '0, '0, '0, '0);
		send_cmd(OP_TICK, '0, '0, -16'sd1, '0, '0);
		send_cmd(OP_TICK, '0, '0, 16'sd100, '0, '0);
		load_settings(16'd2, 16'd6, 16'd3, 16'd1, VEL_MAX, VEL_MAX);
		send_cmd(OP_NOTE_ON, VEL_MAX, '1, '0, '0, '0);
		send_cmd(OP_WRITE, '0, '0, '0, '1, -16'sd32768);
		send_cmd(OP_TICK, '0, '0, 16'sd32767, '0, '0);
		send_cmd(OP_TICK, '0, '0, -16'sd32768, '0, '0);
		send_cmd(OP_TICK, '0, '0, 16'sd32767, '0, '0);
		send_cmd(OP_TICK, '0, '0, -16'sd32768, '0, '0);
		send_cmd(OP_NOTE_ON, 7'd64, 32'h0400_0000, '0, '0, '0);
		send_cmd(OP_TICK, '0, '0, '0, '0, '0);
		send_cmd(OP_TICK, '0, '0, 16'sd12345, '0, '0);
		send_cmd(OP_TICK, '0, '0, -16'sd12345, '0, '0);
		send_cmd(OP_RELEASE, '0, '0, '0, '0, '0);
		send_cmd(OP_WRITE, '0, '0, '0, '0, 16'sd32767);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: load_settings(16'd0, 16'd0, 16'd0, 16'd0, VEL_MAX, VEL_MAX);
				1: load_settings(16'd3, 16'd9, 16'd5, 16'd2, VEL_MAX, 7'd64);
				2: load_settings(16'd10, 16'd1, 16'd0, 16'd12, 7'd64, 7'd0);
				3: load_settings(16'd1, 16'd1, 16'd1, 16'd1, 7'd1, 7'd1);
				4: load_settings('1, '1, '1, '1, VEL_MAX, VEL_MAX);
				5: load_settings('1, '0, '0, '1, 7'd0, 7'd0);
				7: load_settings('0, '1, '1, '0, VEL_MAX, VEL_MAX);
				8: load_settings(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
					TIME_W'($urandom), VEL_W'($urandom), VEL_W'($urandom));
				default: load_settings(TIME_W'($urandom_range(12, 0)), TIME_W'($urandom_range(12, 0)),
					TIME_W'($urandom_range(12, 0)), TIME_W'($urandom_range(12, 0)),
					VEL_W'($urandom), VEL_W'($urandom));
			endcase
			case (p % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 87; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 87; end
				default: begin in_idle_pct = 25; out_stall_pct = 25; end
			endcase
			if (p == 9) begin
				in_idle_pct = 0;
				out_stall_pct = 0;
				long_hold = 1'b1;
			end
			if (p == 1)
				play_notes(1, 1'b1);
			else
				play_notes(1, 1'b0);
		end

		drain_voice();
		if (errors == 0 && mix_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
